// ----- rtl/dense_graph_shortest_path_core_assert.svh -----
// Assertion macros for the shortest path core checker.
// Depends on nothing; the caller provides i_clk and i_rst_n.
`ifndef DENSE_GRAPH_SHORTEST_PATH_CORE_ASSERT_SVH
`define DENSE_GRAPH_SHORTEST_PATH_CORE_ASSERT_SVH

// Same-cycle implication.
`define DGSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DGSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dgsp_pkg.sv -----
// Shared types, codes and constants of the shortest path core.
// Used by the controller, the datapath, the top level and the checker.
package dgsp_pkg;

    localparam int MAX_NODES_DEF     = 64;
    localparam int STOP_ID_COUNT_DEF = 1024;
    localparam int WEIGHT_BITS_DEF   = 16;

    localparam int KIND_W   = 2;
    localparam int STOP_W   = 10;
    localparam int WIN_W    = 16;
    localparam int DIST_W   = 22;
    localparam int STATUS_W = 2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_REG,
        KIND_EDGE,
        KIND_QUERY,
        KIND_NONE
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_PATH,
        ST_NOPATH,
        ST_START_MISSING,
        ST_END_MISSING
    } t_result_code;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_CAPTURE,
        CMD_LKA_ALIAS,
        CMD_LKA_SID,
        CMD_LKA_CHK,
        CMD_LKB_ALIAS,
        CMD_LKB_SID,
        CMD_LKB_CHK,
        CMD_REGISTER,
        CMD_EDGE_AB,
        CMD_EDGE_BA,
        CMD_EMIT_ERRA,
        CMD_EMIT_ERRB,
        CMD_EMIT_NOPATH,
        CMD_SINIT,
        CMD_SCAN,
        CMD_NEXT,
        CMD_WALK_START,
        CMD_WALK_RD,
        CMD_WALK_STEP,
        CMD_OUT_RD,
        CMD_OUT_SID,
        CMD_OUT_EMIT
    } t_cmd;

    typedef struct packed {
        logic  clr_done;
        t_kind kind;
        logic  ha;
        logic  hb;
        logic  scan_done;
        logic  min_found;
        logic  nb_reached;
        logic  walk_end;
        logic  out_free;
        logic  k_zero;
    } t_dp_status;

endpackage

// ----- rtl/dgsp_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dgsp_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dgsp_ctrl.sv -----
// Controller state machine of the shortest path core.
// Depends on dgsp_pkg; drives commands to dgsp_dp and reads its status.
module dgsp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  dgsp_pkg::t_dp_status i_status,
    output dgsp_pkg::t_cmd      o_cmd,
    output logic                o_stall
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DEC, S_LA2, S_LA3, S_REG, S_LB1, S_LB2, S_LB3, S_CHK,
        S_E1, S_E2, S_ERRA, S_ERRB, S_SINIT, S_SCAN, S_NEXT, S_RCH, S_NOPATH,
        S_W1, S_W2, S_O1, S_O2, S_O3
    } t_state;

    t_state r_state, n_state;
    logic   r_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = dgsp_pkg::CMD_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd = dgsp_pkg::CMD_CLEAR;
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd   = dgsp_pkg::CMD_CAPTURE;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_status.kind == dgsp_pkg::KIND_NONE) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd   = dgsp_pkg::CMD_LKA_ALIAS;
                    n_state = S_LA2;
                end
            end
            S_LA2: begin
                o_cmd   = dgsp_pkg::CMD_LKA_SID;
                n_state = S_LA3;
            end
            S_LA3: begin
                o_cmd   = dgsp_pkg::CMD_LKA_CHK;
                n_state = (i_status.kind == dgsp_pkg::KIND_REG) ? S_REG : S_LB1;
            end
            S_REG: begin
                o_cmd   = dgsp_pkg::CMD_REGISTER;
                n_state = S_IDLE;
            end
            S_LB1: begin
                o_cmd   = dgsp_pkg::CMD_LKB_ALIAS;
                n_state = S_LB2;
            end
            S_LB2: begin
                o_cmd   = dgsp_pkg::CMD_LKB_SID;
                n_state = S_LB3;
            end
            S_LB3: begin
                o_cmd   = dgsp_pkg::CMD_LKB_CHK;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_status.kind == dgsp_pkg::KIND_EDGE) begin
                    n_state = (i_status.ha && i_status.hb) ? S_E1 : S_IDLE;
                end else if (!i_status.ha) begin
                    n_state = S_ERRA;
                end else if (!i_status.hb) begin
                    n_state = S_ERRB;
                end else begin
                    n_state = S_SINIT;
                end
            end
            S_E1: begin
                o_cmd   = dgsp_pkg::CMD_EDGE_AB;
                n_state = S_E2;
            end
            S_E2: begin
                o_cmd   = dgsp_pkg::CMD_EDGE_BA;
                n_state = S_IDLE;
            end
            S_ERRA: begin
                o_cmd = dgsp_pkg::CMD_EMIT_ERRA;
                if (i_status.out_free) n_state = i_status.hb ? S_IDLE : S_ERRB;
            end
            S_ERRB: begin
                o_cmd = dgsp_pkg::CMD_EMIT_ERRB;
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_SINIT: begin
                o_cmd   = dgsp_pkg::CMD_SINIT;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd = dgsp_pkg::CMD_SCAN;
                if (i_status.scan_done) n_state = S_NEXT;
            end
            S_NEXT: begin
                o_cmd   = dgsp_pkg::CMD_NEXT;
                n_state = i_status.min_found ? S_SCAN : S_RCH;
            end
            S_RCH: begin
                if (i_status.nb_reached) begin
                    o_cmd   = dgsp_pkg::CMD_WALK_START;
                    n_state = S_W1;
                end else begin
                    n_state = S_NOPATH;
                end
            end
            S_NOPATH: begin
                o_cmd = dgsp_pkg::CMD_EMIT_NOPATH;
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_W1: begin
                o_cmd   = dgsp_pkg::CMD_WALK_RD;
                n_state = S_W2;
            end
            S_W2: begin
                o_cmd   = dgsp_pkg::CMD_WALK_STEP;
                n_state = i_status.walk_end ? S_O1 : S_W1;
            end
            S_O1: begin
                o_cmd   = dgsp_pkg::CMD_OUT_RD;
                n_state = S_O2;
            end
            S_O2: begin
                o_cmd   = dgsp_pkg::CMD_OUT_SID;
                n_state = S_O3;
            end
            S_O3: begin
                o_cmd = dgsp_pkg::CMD_OUT_EMIT;
                if (i_status.out_free) n_state = i_status.k_zero ? S_IDLE : S_O1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_stall = r_stall;

endmodule

// ----- rtl/dgsp_dp.sv -----
// Datapath of the shortest path core: graph memories, search state, output register.
// Depends on dgsp_pkg and dgsp_ram; driven by commands from dgsp_ctrl.
module dgsp_dp #(
    parameter int MAX_NODES     = dgsp_pkg::MAX_NODES_DEF,
    parameter int STOP_ID_COUNT = dgsp_pkg::STOP_ID_COUNT_DEF,
    parameter int WEIGHT_BITS   = dgsp_pkg::WEIGHT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dgsp_pkg::t_cmd                    i_cmd,
    input  logic [dgsp_pkg::KIND_W-1:0]       i_kind,
    input  logic [dgsp_pkg::STOP_W-1:0]       i_stop_a,
    input  logic [dgsp_pkg::STOP_W-1:0]       i_stop_b,
    input  logic [dgsp_pkg::WIN_W-1:0]        i_weight,
    input  logic                              i_stall,
    output dgsp_pkg::t_dp_status              o_status,
    output logic                              o_valid,
    output logic [dgsp_pkg::STOP_W-1:0]       o_stop_id,
    output logic [dgsp_pkg::STATUS_W-1:0]     o_result,
    output logic [dgsp_pkg::DIST_W-1:0]       o_total_distance,
    output logic                              o_last
);

    localparam int NIW    = $clog2(MAX_NODES);
    localparam int CW     = $clog2(MAX_NODES + 1);
    localparam int AAW    = $clog2(STOP_ID_COUNT);
    localparam int ADJ_D  = MAX_NODES * MAX_NODES;
    localparam int ADJ_AW = $clog2(ADJ_D);
    localparam int CLR_N  = (ADJ_D > STOP_ID_COUNT) ? ADJ_D : STOP_ID_COUNT;
    localparam int CLW    = $clog2(CLR_N);
    localparam int DW     = dgsp_pkg::DIST_W;
    localparam int SUM_W  = ((DW > WEIGHT_BITS) ? DW : WEIGHT_BITS) + 1;
    localparam int REC_W  = DW + NIW;

    dgsp_pkg::t_kind               r_kind;
    logic [dgsp_pkg::STOP_W-1:0]   r_sa, r_sb;
    logic [WEIGHT_BITS-1:0]        r_wt;
    logic [CW-1:0]                 r_count;
    logic [CLW-1:0]                r_clr;
    logic                          r_rng, r_ha, r_hb;
    logic [NIW-1:0]                r_na, r_nb;
    logic [MAX_NODES-1:0]          r_settled, r_reached;
    logic [NIW-1:0]                r_cur;
    logic [DW-1:0]                 r_dcur;
    logic [CW-1:0]                 r_i;
    logic                          r_pv;
    logic [NIW-1:0]                r_pi;
    logic                          r_min_found;
    logic [NIW-1:0]                r_min_idx;
    logic [DW-1:0]                 r_min_d;
    logic [NIW-1:0]                r_walk;
    logic [CW-1:0]                 r_len;
    logic [NIW-1:0]                r_k;
    logic [DW-1:0]                 r_total;
    logic                          r_o_valid;
    logic [dgsp_pkg::STOP_W-1:0]   r_o_stop;
    logic [dgsp_pkg::STATUS_W-1:0] r_o_result;
    logic [DW-1:0]                 r_o_dist;
    logic                          r_o_last;

    logic                          alias_we;
    logic [AAW-1:0]                alias_waddr, alias_raddr;
    logic [NIW-1:0]                alias_wdata, alias_rdata;
    logic                          sid_we;
    logic [NIW-1:0]                sid_waddr, sid_raddr;
    logic [dgsp_pkg::STOP_W-1:0]   sid_rdata;
    logic                          adj_we;
    logic [ADJ_AW-1:0]             adj_waddr, adj_raddr;
    logic [WEIGHT_BITS-1:0]        adj_wdata, adj_rdata;
    logic                          drec_we;
    logic [NIW-1:0]                drec_waddr, drec_raddr;
    logic [REC_W-1:0]              drec_wdata, drec_rdata;
    logic                          path_we;
    logic [NIW-1:0]                path_rdata;

    logic                          out_free, a_in_range, b_in_range, reg_ok, walk_end;
    logic                          out_load;
    logic [DW-1:0]                 rec_d;
    logic [NIW-1:0]                rec_pred;
    logic [SUM_W-1:0]              sum;
    logic [DW-1:0]                 nd, eff_d;
    logic                          relax, eff_r, cand;

    assign out_free   = !r_o_valid || !i_stall;
    assign out_load   = out_free && (i_cmd inside {dgsp_pkg::CMD_EMIT_ERRA,
                        dgsp_pkg::CMD_EMIT_ERRB, dgsp_pkg::CMD_EMIT_NOPATH,
                        dgsp_pkg::CMD_OUT_EMIT});
    assign a_in_range = 32'(r_sa) < STOP_ID_COUNT;
    assign b_in_range = 32'(r_sb) < STOP_ID_COUNT;
    assign reg_ok     = !r_ha && a_in_range && (r_count < CW'(MAX_NODES));
    assign walk_end   = (r_walk == r_na) || (r_len == CW'(MAX_NODES));
    assign rec_d      = drec_rdata[REC_W-1:NIW];
    assign rec_pred   = drec_rdata[NIW-1:0];

    always_comb begin
        sum   = SUM_W'(r_dcur) + SUM_W'(adj_rdata);
        nd    = (sum > SUM_W'(dgsp_pkg::DIST_MAX)) ? dgsp_pkg::DIST_MAX : sum[DW-1:0];
        relax = r_pv && (adj_rdata != '0) && !r_settled[r_pi]
                && (!r_reached[r_pi] || (nd < rec_d));
        eff_d = relax ? nd : rec_d;
        eff_r = relax || r_reached[r_pi];
        cand  = r_pv && eff_r && !r_settled[r_pi] && (!r_min_found || (eff_d < r_min_d));
    end

    always_comb begin
        alias_we    = 1'b0;
        alias_waddr = AAW'(r_sa);
        alias_wdata = NIW'(r_count);
        alias_raddr = (i_cmd == dgsp_pkg::CMD_LKB_ALIAS) ? AAW'(r_sb) : AAW'(r_sa);
        sid_we      = (i_cmd == dgsp_pkg::CMD_REGISTER) && reg_ok;
        sid_waddr   = NIW'(r_count);
        sid_raddr   = ((i_cmd == dgsp_pkg::CMD_LKA_SID) || (i_cmd == dgsp_pkg::CMD_LKB_SID))
                      ? alias_rdata : path_rdata;
        adj_we      = 1'b0;
        adj_waddr   = ADJ_AW'(r_na * MAX_NODES + r_nb);
        adj_wdata   = r_wt;
        adj_raddr   = ADJ_AW'(r_cur * MAX_NODES + r_i[NIW-1:0]);
        drec_we     = 1'b0;
        drec_waddr  = r_pi;
        drec_wdata  = {nd, r_cur};
        drec_raddr  = (i_cmd == dgsp_pkg::CMD_WALK_RD) ? r_walk : r_i[NIW-1:0];
        path_we     = (i_cmd == dgsp_pkg::CMD_WALK_RD);
        unique case (i_cmd)
            dgsp_pkg::CMD_CLEAR: begin
                alias_we    = 32'(r_clr) < STOP_ID_COUNT;
                alias_waddr = AAW'(r_clr);
                alias_wdata = '0;
                adj_we      = 32'(r_clr) < ADJ_D;
                adj_waddr   = ADJ_AW'(r_clr);
                adj_wdata   = '0;
            end
            dgsp_pkg::CMD_REGISTER: alias_we = reg_ok;
            dgsp_pkg::CMD_EDGE_AB:  adj_we = 1'b1;
            dgsp_pkg::CMD_EDGE_BA: begin
                adj_we    = 1'b1;
                adj_waddr = ADJ_AW'(r_nb * MAX_NODES + r_na);
            end
            dgsp_pkg::CMD_SINIT: begin
                drec_we    = 1'b1;
                drec_waddr = r_na;
                drec_wdata = {DW'(0), r_na};
            end
            dgsp_pkg::CMD_SCAN: drec_we = relax;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
            r_pv      <= 1'b0;
        end else begin
            r_pv <= (i_cmd == dgsp_pkg::CMD_SCAN) && (r_i < r_count);
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (i_cmd)
                dgsp_pkg::CMD_CLEAR: r_clr <= r_clr + 1'b1;
                dgsp_pkg::CMD_CAPTURE: begin
                    r_kind <= dgsp_pkg::t_kind'(i_kind);
                    r_sa   <= i_stop_a;
                    r_sb   <= i_stop_b;
                    r_wt   <= WEIGHT_BITS'(i_weight);
                end
                dgsp_pkg::CMD_LKA_SID: begin
                    r_na  <= alias_rdata;
                    r_rng <= a_in_range && (CW'(alias_rdata) < r_count);
                end
                dgsp_pkg::CMD_LKA_CHK: r_ha <= r_rng && (sid_rdata == r_sa);
                dgsp_pkg::CMD_LKB_SID: begin
                    r_nb  <= alias_rdata;
                    r_rng <= b_in_range && (CW'(alias_rdata) < r_count);
                end
                dgsp_pkg::CMD_LKB_CHK: r_hb <= r_rng && (sid_rdata == r_sb);
                dgsp_pkg::CMD_REGISTER: begin
                    if (reg_ok) r_count <= r_count + 1'b1;
                end
                dgsp_pkg::CMD_EMIT_ERRA: begin
                    if (out_free) begin
                        r_o_stop   <= r_sa;
                        r_o_result <= dgsp_pkg::ST_START_MISSING;
                        r_o_dist   <= '0;
                        r_o_last   <= r_hb;
                    end
                end
                dgsp_pkg::CMD_EMIT_ERRB: begin
                    if (out_free) begin
                        r_o_stop   <= r_sb;
                        r_o_result <= dgsp_pkg::ST_END_MISSING;
                        r_o_dist   <= '0;
                        r_o_last   <= 1'b1;
                    end
                end
                dgsp_pkg::CMD_EMIT_NOPATH: begin
                    if (out_free) begin
                        r_o_stop   <= r_sb;
                        r_o_result <= dgsp_pkg::ST_NOPATH;
                        r_o_dist   <= '0;
                        r_o_last   <= 1'b1;
                    end
                end
                dgsp_pkg::CMD_SINIT: begin
                    r_settled   <= MAX_NODES'(1) << r_na;
                    r_reached   <= MAX_NODES'(1) << r_na;
                    r_cur       <= r_na;
                    r_dcur      <= '0;
                    r_i         <= '0;
                    r_min_found <= 1'b0;
                end
                dgsp_pkg::CMD_SCAN: begin
                    if (r_i < r_count) begin
                        r_pi <= r_i[NIW-1:0];
                        r_i  <= r_i + 1'b1;
                    end
                    if (relax) r_reached[r_pi] <= 1'b1;
                    if (cand) begin
                        r_min_found <= 1'b1;
                        r_min_idx   <= r_pi;
                        r_min_d     <= eff_d;
                    end
                end
                dgsp_pkg::CMD_NEXT: begin
                    if (r_min_found) begin
                        r_cur                <= r_min_idx;
                        r_dcur               <= r_min_d;
                        r_settled[r_min_idx] <= 1'b1;
                        r_i                  <= '0;
                        r_min_found          <= 1'b0;
                    end
                end
                dgsp_pkg::CMD_WALK_START: begin
                    r_walk <= r_nb;
                    r_len  <= '0;
                end
                dgsp_pkg::CMD_WALK_RD: r_len <= r_len + 1'b1;
                dgsp_pkg::CMD_WALK_STEP: begin
                    if (r_len == CW'(1)) r_total <= rec_d;
                    if (walk_end) begin
                        r_k <= NIW'(r_len - 1'b1);
                    end else begin
                        r_walk <= rec_pred;
                    end
                end
                dgsp_pkg::CMD_OUT_EMIT: begin
                    if (out_free) begin
                        r_o_stop   <= sid_rdata;
                        r_o_result <= dgsp_pkg::ST_PATH;
                        r_o_dist   <= r_total;
                        r_o_last   <= (r_k == '0);
                        r_k        <= r_k - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    dgsp_ram #(.W(NIW), .D(STOP_ID_COUNT)) u_alias (
        .i_clk(i_clk), .i_we(alias_we), .i_waddr(alias_waddr), .i_wdata(alias_wdata),
        .i_raddr(alias_raddr), .o_rdata(alias_rdata)
    );

    dgsp_ram #(.W(dgsp_pkg::STOP_W), .D(MAX_NODES)) u_sid (
        .i_clk(i_clk), .i_we(sid_we), .i_waddr(sid_waddr), .i_wdata(r_sa),
        .i_raddr(sid_raddr), .o_rdata(sid_rdata)
    );

    dgsp_ram #(.W(WEIGHT_BITS), .D(ADJ_D)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );

    dgsp_ram #(.W(REC_W), .D(MAX_NODES)) u_drec (
        .i_clk(i_clk), .i_we(drec_we), .i_waddr(drec_waddr), .i_wdata(drec_wdata),
        .i_raddr(drec_raddr), .o_rdata(drec_rdata)
    );

    dgsp_ram #(.W(NIW), .D(MAX_NODES)) u_path (
        .i_clk(i_clk), .i_we(path_we), .i_waddr(r_len[NIW-1:0]), .i_wdata(r_walk),
        .i_raddr(r_k), .o_rdata(path_rdata)
    );

    always_comb begin
        o_status.clr_done   = (r_clr == CLW'(CLR_N - 1));
        o_status.kind       = r_kind;
        o_status.ha         = r_ha;
        o_status.hb         = r_hb;
        o_status.scan_done  = (r_i == r_count) && !r_pv;
        o_status.min_found  = r_min_found;
        o_status.nb_reached = r_reached[r_nb];
        o_status.walk_end   = walk_end;
        o_status.out_free   = out_free;
        o_status.k_zero     = (r_k == '0);
    end

    assign o_valid          = r_o_valid;
    assign o_stop_id        = r_o_stop;
    assign o_result         = r_o_result;
    assign o_total_distance = r_o_dist;
    assign o_last           = r_o_last;

endmodule

// ----- rtl/dense_graph_shortest_path_core.sv -----
// Top level of the dense graph shortest path core.
// Depends on dgsp_pkg, dgsp_ctrl and dgsp_dp.
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+-------------------------------------------------
//  request  | i_valid  | o_stall  | i_kind, i_stop_a, i_stop_b, i_weight
//  result   | o_valid  | i_stall  | o_stop_id, o_status, o_total_distance, o_last
//
// After reset a sweep clears the adjacency and alias memories; o_stall stays high until
// it ends. A query makes one adjacency read per registered node per settled node
// through the single adjacency read port.
// A stalled result holds in the output register; the next item waits for it only
// when a new result must be loaded.
module dense_graph_shortest_path_core #(
    parameter int MAX_NODES     = dgsp_pkg::MAX_NODES_DEF,
    parameter int STOP_ID_COUNT = dgsp_pkg::STOP_ID_COUNT_DEF,
    parameter int WEIGHT_BITS   = dgsp_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dgsp_pkg::KIND_W-1:0]   i_kind,
    input  logic [dgsp_pkg::STOP_W-1:0]   i_stop_a,
    input  logic [dgsp_pkg::STOP_W-1:0]   i_stop_b,
    input  logic [dgsp_pkg::WIN_W-1:0]    i_weight,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dgsp_pkg::STOP_W-1:0]   o_stop_id,
    output logic [dgsp_pkg::STATUS_W-1:0] o_status,
    output logic [dgsp_pkg::DIST_W-1:0]   o_total_distance,
    output logic                          o_last
);

    dgsp_pkg::t_cmd       cmd;
    dgsp_pkg::t_dp_status dp_status;

    dgsp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    dgsp_dp #(
        .MAX_NODES     (MAX_NODES),
        .STOP_ID_COUNT (STOP_ID_COUNT),
        .WEIGHT_BITS   (WEIGHT_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_kind           (i_kind),
        .i_stop_a         (i_stop_a),
        .i_stop_b         (i_stop_b),
        .i_weight         (i_weight),
        .i_stall          (i_stall),
        .o_status         (dp_status),
        .o_valid          (o_valid),
        .o_stop_id        (o_stop_id),
        .o_result         (o_status),
        .o_total_distance (o_total_distance),
        .o_last           (o_last)
    );

endmodule

// ----- rtl/dgsp_checker.sv -----
// Port-level checker of the shortest path core, bound to the top level.
// Depends on dgsp_pkg and dense_graph_shortest_path_core_assert.svh.
`include "dense_graph_shortest_path_core_assert.svh"

module dgsp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [dgsp_pkg::KIND_W-1:0]   i_kind,
    input logic [dgsp_pkg::STOP_W-1:0]   i_stop_a,
    input logic [dgsp_pkg::STOP_W-1:0]   i_stop_b,
    input logic [dgsp_pkg::WIN_W-1:0]    i_weight,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [dgsp_pkg::STOP_W-1:0]   o_stop_id,
    input logic [dgsp_pkg::STATUS_W-1:0] o_status,
    input logic [dgsp_pkg::DIST_W-1:0]   o_total_distance,
    input logic                          o_last
);

    `DGSP_ASSERT_NEXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_stop_id) && $stable(o_status) && $stable(o_last),
        "stalled result changed")
    `DGSP_ASSERT_NEXT(a_busy_after_transfer, i_valid && !o_stall, o_stall,
        "request side ready right after a transfer")
    `DGSP_ASSERT_NOW(a_final_codes_last,
        o_valid && (o_status == dgsp_pkg::ST_NOPATH || o_status == dgsp_pkg::ST_END_MISSING),
        o_last, "no-path or end-missing result not marked last")
    `DGSP_ASSERT_NOW(a_error_zero_dist, o_valid && o_status != dgsp_pkg::ST_PATH,
        o_total_distance == '0, "non-path result carries a distance")

endmodule

bind dense_graph_shortest_path_core dgsp_checker u_dgsp_checker (.*);

// ----- verif/tb_dense_graph_shortest_path_core.sv -----
// Self-checking testbench for dense_graph_shortest_path_core.
// Predicts each query's path, no-path and missing-stop results in SystemVerilog.
// Depends on dgsp_pkg and the core RTL.
module tb_dense_graph_shortest_path_core;

    localparam int NODES     = dgsp_pkg::MAX_NODES_DEF;
    localparam int STOP_IDS  = dgsp_pkg::STOP_ID_COUNT_DEF;
    localparam int LIMIT     = 3000000;

    typedef logic [dgsp_pkg::STOP_W-1:0] t_stop;
    typedef logic [dgsp_pkg::WIN_W-1:0]  t_wt;
    typedef logic [dgsp_pkg::DIST_W-1:0] t_total;
    typedef logic [6:0]                  t_node;

    typedef struct packed {
        t_stop                  stop_id;
        dgsp_pkg::t_result_code status;
        t_total                 total;
        logic                   last;
    } t_hop;

    typedef struct packed {
        dgsp_pkg::t_kind kind;
        t_stop           sa;
        t_stop           sb;
        t_wt             wt;
        logic            typed;
        t_hop            hop;
    } t_row;

    logic                          i_clk = 0;
    logic                          i_rst_n = 0;
    logic                          i_valid = 0;
    logic                          o_stall;
    logic [dgsp_pkg::KIND_W-1:0]   i_kind = '0;
    t_stop                         i_stop_a = '0;
    t_stop                         i_stop_b = '0;
    t_wt                           i_weight = '0;
    logic                          o_valid;
    logic                          i_stall = 0;
    t_stop                         o_stop_id;
    logic [dgsp_pkg::STATUS_W-1:0] o_status;
    t_total                        o_total_distance;
    logic                          o_last;

    dense_graph_shortest_path_core u_dut (.*);

    // graph shadow
    logic               alias_ok [STOP_IDS];
    t_node              alias_node [STOP_IDS];
    t_stop              stop_of [NODES];
    int                 node_total;
    t_wt                adj [NODES][NODES];

    t_hop  route_q[$];
    int    errors, mismatches, results_seen, queries, cycles;

    initial forever #5 i_clk = ~i_clk;

    function automatic bit find_node(t_stop s, output int n);
        n = int'(alias_node[s]);
        return alias_ok[s] && n < node_total;
    endfunction

    function automatic void hop_push(t_stop s, dgsp_pkg::t_result_code c,
                                     t_total d, logic l);
        t_hop h;
        h.stop_id = s; h.status = c; h.total = d; h.last = l;
        route_q.push_back(h);
    endfunction

    function automatic void graph_apply(dgsp_pkg::t_kind k, t_stop sa, t_stop sb, t_wt wt);
        int na, nb, cur, len;
        bit ha, hb;
        t_total span [NODES];
        t_node pred [NODES];
        bit done [NODES];
        bit seen [NODES];
        int trail [NODES];
        longint nd;
        case (k)
            dgsp_pkg::KIND_REG: begin
                if (!alias_ok[sa] && node_total < NODES) begin
                    alias_ok[sa] = 1; alias_node[sa] = t_node'(node_total);
                    stop_of[node_total] = sa; node_total++;
                end
            end
            dgsp_pkg::KIND_EDGE: begin
                if (find_node(sa, na) && find_node(sb, nb)) begin
                    adj[na][nb] = wt; adj[nb][na] = wt;
                end
            end
            dgsp_pkg::KIND_QUERY: begin
                queries++;
                ha = find_node(sa, na);
                hb = find_node(sb, nb);
                if (!ha) hop_push(sa, dgsp_pkg::ST_START_MISSING, '0, hb);
                if (!hb) hop_push(sb, dgsp_pkg::ST_END_MISSING, '0, 1'b1);
                if (ha && hb) begin
                    for (int i = 0; i < NODES; i++) begin
                        span[i] = '0; pred[i] = 7'h7f; done[i] = 0; seen[i] = 0;
                    end
                    seen[na] = 1;
                    forever begin
                        cur = NODES;
                        for (int i = 0; i < node_total; i++)
                            if (seen[i] && !done[i] && (cur == NODES || span[i] < span[cur]))
                                cur = i;
                        if (cur == NODES) break;
                        done[cur] = 1;
                        for (int i = 0; i < node_total; i++) begin
                            if (adj[cur][i] == 0 || done[i]) continue;
                            nd = longint'(span[cur]) + longint'(adj[cur][i]);
                            if (nd > longint'(dgsp_pkg::DIST_MAX))
                                nd = longint'(dgsp_pkg::DIST_MAX);
                            if (!seen[i] || nd < longint'(span[i])) begin
                                seen[i] = 1; span[i] = t_total'(nd); pred[i] = t_node'(cur);
                            end
                        end
                    end
                    if (!seen[nb]) hop_push(sb, dgsp_pkg::ST_NOPATH, '0, 1'b1);
                    else begin
                        len = 0; cur = nb;
                        while (len < NODES) begin
                            trail[len++] = cur;
                            if (cur == na || pred[cur] >= NODES) break;
                            cur = int'(pred[cur]);
                        end
                        for (int j = 0; j < len; j++)
                            hop_push(stop_of[trail[len-1-j]], dgsp_pkg::ST_PATH, span[nb],
                                     j == len - 1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(dgsp_pkg::t_kind k, t_stop sa, t_stop sb,
                             t_wt wt, logic typed, t_hop hop);
        int qlen;
        @(negedge i_clk);
        i_valid <= 1; i_kind <= k; i_stop_a <= sa; i_stop_b <= sb; i_weight <= wt;
        do @(posedge i_clk); while (o_stall);
        qlen = route_q.size();
        graph_apply(k, sa, sb, wt);
        if (typed && (route_q.size() <= qlen || route_q[qlen] !== hop)) begin
            errors++;
            $display("table row disagrees with predictor: %p", hop);
        end
        // hold valid through bursts; drop it for a random gap
        if ($urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_valid <= 0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    // result check
    always @(posedge i_clk) begin
        t_hop want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (route_q.size() == 0) begin
                errors++; mismatches++;
                if (mismatches <= 10) $display("unexpected result stop %0d", o_stop_id);
            end else begin
                want = route_q.pop_front();
                if (o_stop_id !== want.stop_id || o_status !== want.status ||
                    o_total_distance !== want.total || o_last !== want.last) begin
                    errors++; mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.stop_id, want.status, want.total, want.last,
                                 o_stop_id, o_status, o_total_distance, o_last);
                end
            end
        end
    end

    // receiver stall pattern
    initial begin
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 40) == 0) begin
                i_stall <= 0;
                repeat ($urandom_range(20, 80)) @(negedge i_clk);
            end else begin
                case ($urandom_range(0, 2))
                    0: i_stall <= 0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    default: i_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("dense_graph_shortest_path_core regression: fail");
                $finish;
            end
        end
    end

    function automatic t_row mk(dgsp_pkg::t_kind k, int sa, int sb, int wt);
        t_row r;
        r = '0; r.kind = k; r.sa = t_stop'(sa); r.sb = t_stop'(sb); r.wt = t_wt'(wt);
        return r;
    endfunction

    function automatic t_row mkx(dgsp_pkg::t_kind k, int sa, int sb,
                                 dgsp_pkg::t_result_code c, int s, int l);
        t_row r;
        r = mk(k, sa, sb, 0);
        r.typed = 1; r.hop.stop_id = t_stop'(s); r.hop.status = c; r.hop.total = '0;
        r.hop.last = 1'(l);
        return r;
    endfunction

    initial begin
        t_row rows[$];
        t_hop none;
        int pool[$];
        int k, a, b, w;
        for (int i = 0; i < STOP_IDS; i++) begin alias_ok[i] = 0; alias_node[i] = 0; end
        for (int i = 0; i < NODES; i++) begin
            stop_of[i] = 0;
            for (int j = 0; j < NODES; j++) adj[i][j] = 0;
        end
        node_total = 0; errors = 0; mismatches = 0; results_seen = 0; queries = 0;
        none = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;

        rows.push_back(mkx(dgsp_pkg::KIND_QUERY, 5, 1023, dgsp_pkg::ST_START_MISSING, 5, 0));
        rows.push_back(mk(dgsp_pkg::KIND_REG, 0, 0, 0));
        rows.push_back(mk(dgsp_pkg::KIND_REG, 1023, 0, 0));
        rows.push_back(mk(dgsp_pkg::KIND_REG, 1023, 0, 0));
        rows.push_back(mk(dgsp_pkg::KIND_REG, 682, 0, 0));
        rows.push_back(mk(dgsp_pkg::KIND_REG, 341, 0, 0));
        rows.push_back(mkx(dgsp_pkg::KIND_QUERY, 0, 1023, dgsp_pkg::ST_NOPATH, 1023, 1));
        rows.push_back(mkx(dgsp_pkg::KIND_QUERY, 0, 7, dgsp_pkg::ST_END_MISSING, 7, 1));
        rows.push_back(mkx(dgsp_pkg::KIND_QUERY, 9, 0, dgsp_pkg::ST_START_MISSING, 9, 1));
        rows.push_back(mk(dgsp_pkg::KIND_QUERY, 682, 682, 0));
        rows.push_back(mk(dgsp_pkg::KIND_EDGE, 0, 1023, 65535));
        rows.push_back(mk(dgsp_pkg::KIND_EDGE, 1023, 682, 1));
        rows.push_back(mk(dgsp_pkg::KIND_EDGE, 0, 682, 65535));
        rows.push_back(mk(dgsp_pkg::KIND_EDGE, 0, 0, 5));
        rows.push_back(mk(dgsp_pkg::KIND_EDGE, 0, 9, 5));
        rows.push_back(mk(dgsp_pkg::KIND_NONE, 0, 682, 5));
        rows.push_back(mk(dgsp_pkg::KIND_QUERY, 0, 682, 0));
        rows.push_back(mk(dgsp_pkg::KIND_EDGE, 341, 682, 21845));
        rows.push_back(mk(dgsp_pkg::KIND_QUERY, 341, 0, 0));
        rows.push_back(mk(dgsp_pkg::KIND_EDGE, 0, 1023, 0));
        rows.push_back(mk(dgsp_pkg::KIND_QUERY, 0, 341, 0));
        rows.push_back(mk(dgsp_pkg::KIND_QUERY, 1023, 1023, 0));
        foreach (rows[i]) send_item(rows[i].kind, rows[i].sa, rows[i].sb, rows[i].wt,
                                    rows[i].typed, rows[i].hop);

        pool = '{0, 1023, 682, 341};
        // grow the node table with random stops, wiring random edges and querying between them as it grows
        for (int i = 0; i < 118; i++) begin
            k = $urandom_range(0, 19);
            if (k < 5 || node_total < 8) begin
                a = $urandom_range(0, 1023);
                if (node_total < NODES) pool.push_back(a);
                send_item(dgsp_pkg::KIND_REG, t_stop'(a), '0, '0, 1'b0, none);
            end else if (k < 14) begin
                a = pool[$urandom_range(0, pool.size() - 1)];
                b = pool[$urandom_range(0, pool.size() - 1)];
                w = ($urandom_range(0, 5) == 0) ? 0 :
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(1, 40);
                send_item(dgsp_pkg::KIND_EDGE, t_stop'(a), t_stop'(b), t_wt'(w), 1'b0, none);
            end else if (k < 18) begin
                a = pool[$urandom_range(0, pool.size() - 1)];
                b = pool[$urandom_range(0, pool.size() - 1)];
                send_item(dgsp_pkg::KIND_QUERY, t_stop'(a), t_stop'(b), '0, 1'b0, none);
            end else begin
                send_item(dgsp_pkg::t_kind'($urandom_range(0, 3)),
                          t_stop'($urandom_range(0, 1023)),
                          t_stop'($urandom_range(0, 1023)),
                          t_wt'($urandom_range(0, 65535)), 1'b0, none);
            end
        end
        @(negedge i_clk) i_valid <= 0;
        while (route_q.size() != 0) @(posedge i_clk);
        repeat (6000) @(posedge i_clk);
        $display("covered %0d queries, %0d results, %0d nodes registered",
                 queries, results_seen, node_total);
        if (errors == 0 && route_q.size() == 0)
            $display("dense_graph_shortest_path_core regression: pass");
        else
            $display("dense_graph_shortest_path_core regression: fail");
        $finish;
    end
endmodule

// ----- dense_graph_shortest_path_core.f -----
+incdir+rtl
rtl/dgsp_pkg.sv
rtl/dgsp_ram.sv
rtl/dgsp_ctrl.sv
rtl/dgsp_dp.sv
rtl/dense_graph_shortest_path_core.sv
rtl/dgsp_checker.sv
verif/tb_dense_graph_shortest_path_core.sv
